/* sv/simplified_des_cipher_top_assert.svh */
// Assertion macros for the S-DES block checker.
// Clock aclk and active-low reset aresetn are taken from the enclosing scope.
`ifndef SIMPLIFIED_DES_CIPHER_TOP_ASSERT_SVH
`define SIMPLIFIED_DES_CIPHER_TOP_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define SDES_ASSERT_NOW(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error(msg);

// Condition a implies condition b in the next cycle.
`define SDES_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error(msg);

`endif

/* sv/sdes_pkg.sv */
package sdes_pkg;

    typedef struct packed {
        logic       action;
        logic [3:0] l;
        logic [3:0] r;
    } sdes_data_t;

    typedef struct packed {
        logic [7:0] k0;
        logic [7:0] k1;
    } sdes_subkeys_t;

    // S-boxes, indexed by {row, col}
    localparam logic [1:0] SBOX0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic logic [7:0] perm_ip(input logic [7:0] b);
        return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic logic [7:0] perm_iip(input logic [7:0] b);
        return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic logic [9:0] perm_p10(input logic [9:0] k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic logic [7:0] perm_p8(input logic [9:0] k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] s);
        return {s[2], s[0], s[1], s[3]};
    endfunction

    function automatic logic [7:0] perm_ep(input logic [3:0] r);
        return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
    endfunction

    function automatic logic [3:0] sbox_idx(input logic [3:0] x);
        return {x[3], x[0], x[2:1]};
    endfunction

    function automatic logic [3:0] feistel_f(input logic [3:0] r, input logic [7:0] sk);
        logic [7:0] e;
        logic [3:0] s;
        e = perm_ep(r) ^ sk;
        s = {SBOX0[sbox_idx(e[7:4])], SBOX1[sbox_idx(e[3:0])]};
        return perm_p4(s);
    endfunction

    function automatic sdes_subkeys_t derive_subkeys(input logic [9:0] key);
        logic [9:0]    p;
        logic [4:0]    hl;
        logic [4:0]    hr;
        sdes_subkeys_t sk;
        p     = perm_p10(key);
        hl    = p[9:5];
        hr    = p[4:0];
        // rotate left by 1, then a total of 3
        sk.k0 = perm_p8({hl[3:0], hl[4], hr[3:0], hr[4]});
        sk.k1 = perm_p8({hl[1:0], hl[4:2], hr[1:0], hr[4:2]});
        return sk;
    endfunction

endpackage

/* sv/sdes_key_sched.sv */
module sdes_key_sched (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [9:0]             cfg_data,
    output sdes_pkg::sdes_subkeys_t subkeys
);
    import sdes_pkg::*;

    sdes_subkeys_t subkeys_reg;
    sdes_subkeys_t subkeys_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        subkeys_next = subkeys_reg;
        if (cfg_valid) begin
            subkeys_next = derive_subkeys(cfg_data);
        end
    end

    // key 0 gives all-zero subkeys
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subkeys_reg <= '0;
        end else begin
            subkeys_reg <= subkeys_next;
        end
    end

    assign subkeys = subkeys_reg;

endmodule

/* sv/sdes_round.sv */
module sdes_round (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sdes_pkg::sdes_data_t    in_data,
    input  sdes_pkg::sdes_subkeys_t subkeys,
    input  logic                    second_round,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sdes_pkg::sdes_data_t    out_data
);
    import sdes_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    sdes_data_t data_reg;
    sdes_data_t data_next;
    logic [7:0] key;

    // decrypt reverses subkey order
    assign key      = (in_data.action ^ second_round) ? subkeys.k1 : subkeys.k0;
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next       = in_valid;
            data_next.action = in_data.action;
            data_next.l      = in_data.l ^ feistel_f(in_data.r, key);
            data_next.r      = in_data.r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/simplified_des_cipher_top.sv */
// S-DES block cipher, one 8-bit block per transaction.
// Input channel s_*: s_tdata carries the block, s_tuser selects
// encrypt (0) or decrypt (1). Output channel m_*: m_tdata carries the result.
// Key channel cfg_*: cfg_data is the 10-bit key, written when cfg_valid is
// high (cfg_ready is always high); write it only while no block is in flight.
// Pipeline: initial permutation register, round-one register, round-two
// register; the inverse permutation is wiring on the last register.
// Throughput: one block per cycle while m_tready is high, set by the three-stage register pipeline.
// Reset: pipeline empties and the key returns to 0.
// Stall: when m_tready is low, each stage holds its block and bubbles ahead
// of it are filled; up to 3 blocks are held before s_tready drops.
module simplified_des_cipher_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] block_in
    input  logic       s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] block_out
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data
);
    import sdes_pkg::*;

    sdes_subkeys_t subkeys;

    logic       v0_reg;
    logic       v0_next;
    sdes_data_t d0_reg;
    sdes_data_t d0_next;
    logic [7:0] ip_val;

    logic       rdy1;
    logic       v1;
    sdes_data_t d1;
    sdes_data_t d1_swap;
    logic       rdy2;
    sdes_data_t d2;

    sdes_key_sched u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .subkeys   (subkeys)
    );

    assign ip_val   = perm_ip(s_tdata);
    assign s_tready = !v0_reg || rdy1;

    always_comb begin
        v0_next = v0_reg;
        d0_next = d0_reg;
        if (s_tready) begin
            v0_next        = s_tvalid;
            d0_next.action = s_tuser;
            d0_next.l      = ip_val[7:4];
            d0_next.r      = ip_val[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
        end
    end

    always_ff @(posedge aclk) begin
        d0_reg <= d0_next;
    end

    sdes_round u_round_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (v0_reg),
        .in_ready     (rdy1),
        .in_data      (d0_reg),
        .subkeys      (subkeys),
        .second_round (1'b0),
        .out_valid    (v1),
        .out_ready    (rdy2),
        .out_data     (d1)
    );

    // half swap between rounds
    assign d1_swap = '{action: d1.action, l: d1.r, r: d1.l};

    sdes_round u_round_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (v1),
        .in_ready     (rdy2),
        .in_data      (d1_swap),
        .subkeys      (subkeys),
        .second_round (1'b1),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (d2)
    );

    assign m_tdata = perm_iip({d2.l, d2.r});

endmodule

/* sv/sdes_checker.sv */
`include "simplified_des_cipher_top_assert.svh"

module sdes_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = m_tvalid && m_tready;

    // blocks in flight
    always_comb begin
        cnt_next = cnt_reg;
        if (in_xact && !out_xact) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!in_xact && out_xact) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `SDES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
    `SDES_ASSERT_NOW(a_no_phantom, m_tvalid, cnt_reg != 2'd0, "result without a block in flight")
    `SDES_ASSERT_NOW(a_full_only, !s_tready, cnt_reg == 2'd3, "input stalled with pipeline not full")
    `SDES_ASSERT_NOW(a_drain_ready, m_tready, s_tready, "input stalled while output drains")

endmodule

bind simplified_des_cipher_top sdes_checker u_sdes_checker (.*);

/* bench/simplified_des_cipher_top_tb.sv */
`timescale 1ns / 1ps

module simplified_des_cipher_top_tb;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } sdes_op_e;

    localparam int KEY_MAX      = 1023;
    localparam int HOLD_CYCLES  = 64;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_BLOCKS = 165;

    // permutation tables, first entry in the top nibble, 1-based from the MSB
    localparam logic [39:0] TAB_P10 = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
                                       4'd8, 4'd6};
    localparam logic [31:0] TAB_P8  = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
    localparam logic [31:0] TAB_IP  = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
    localparam logic [31:0] TAB_IIP = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
    localparam logic [31:0] TAB_EP  = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
    localparam logic [15:0] TAB_P4  = {4'd2, 4'd4, 4'd3, 4'd1};

    // S-boxes, row-major, entry 0 in the top bits
    localparam logic [31:0] BOX_S0 = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                      2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [31:0] BOX_S1 = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                      2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] block_in
    logic       s_tuser;   // [0] action
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [7:0] block_out
    logic       cfg_valid;
    logic       cfg_ready;
    logic [9:0] cfg_data;

    logic [9:0] key_shadow;
    logic [7:0] expected_blocks[$];
    logic [7:0] want_block;
    int         err_count = 0;
    bit         src_no_idle;
    bit         sink_no_idle;
    int         hold_req_count = 0;
    int         hold_ack_count = 0;
    int         hold_left = 0;
    int         sink_run = 0;
    int         sink_gap;

    simplified_des_cipher_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [9:0] select_bits(input logic [9:0] v, input int width,
                                               input logic [39:0] tab, input int n);
        logic [9:0] res;
        int         pos;
        res = '0;
        for (int i = 0; i < n; i++) begin
            pos = int'(tab[(n - 1 - i) * 4 +: 4]);
            res = {res[8:0], v[width - pos]};
        end
        return res;
    endfunction

    function automatic logic [1:0] sbox_out(input logic [31:0] box, input logic [3:0] x);
        int idx;
        idx = int'({x[3], x[0], x[2:1]});
        return box[(15 - idx) * 2 +: 2];
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] x);
        return {x[3:0], x[4]};
    endfunction

    function automatic logic [3:0] round_fn(input logic [3:0] r, input logic [7:0] sk);
        logic [9:0] tmp;
        logic [7:0] e;
        logic [3:0] s;
        tmp = select_bits({6'b0, r}, 4, 40'(TAB_EP), 8);
        e   = tmp[7:0] ^ sk;
        s   = {sbox_out(BOX_S0, e[7:4]), sbox_out(BOX_S1, e[3:0])};
        tmp = select_bits({6'b0, s}, 4, 40'(TAB_P4), 4);
        return tmp[3:0];
    endfunction

    function automatic logic [7:0] sdes_transform(input sdes_op_e op, input logic [9:0] key,
                                                  input logic [7:0] blk);
        logic [9:0] p;
        logic [4:0] kl;
        logic [4:0] kr;
        logic [7:0] rk0;
        logic [7:0] rk1;
        logic [7:0] ka;
        logic [7:0] kb;
        logic [3:0] l;
        logic [3:0] r;
        logic [3:0] t;
        p   = select_bits(key, 10, TAB_P10, 10);
        kl  = rotl5(p[9:5]);
        kr  = rotl5(p[4:0]);
        p   = select_bits({kl, kr}, 10, 40'(TAB_P8), 8);
        rk0 = p[7:0];
        kl  = rotl5(rotl5(kl));
        kr  = rotl5(rotl5(kr));
        p   = select_bits({kl, kr}, 10, 40'(TAB_P8), 8);
        rk1 = p[7:0];
        ka  = (op == OP_DECRYPT) ? rk1 : rk0;
        kb  = (op == OP_DECRYPT) ? rk0 : rk1;
        p   = select_bits({2'b0, blk}, 8, 40'(TAB_IP), 8);
        l   = p[7:4] ^ round_fn(p[3:0], ka);
        r   = p[3:0];
        t   = l;
        l   = r;
        r   = t;
        l   = l ^ round_fn(r, kb);
        p   = select_bits({2'b0, l, r}, 8, 40'(TAB_IIP), 8);
        return p[7:0];
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 40) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic add_expected(input logic [7:0] blk);
        expected_blocks = {expected_blocks, blk};
    endtask

    // scoreboard: record accepted blocks first so a result in the same cycle as its input still matches
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                add_expected(sdes_transform(sdes_op_e'(s_tuser), key_shadow, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    report_error($sformatf("unexpected result 0x%02h", m_tdata));
                end else begin
                    want_block = expected_blocks.pop_front();
                    if (m_tdata !== want_block) begin
                        report_error($sformatf("block_out got 0x%02h exp 0x%02h",
                                               m_tdata, want_block));
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_ack_count != hold_req_count) begin
            hold_ack_count = hold_req_count;
            hold_left      = HOLD_CYCLES;
            m_tready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_no_idle) begin
            m_tready <= 1'b1;
        end else if (sink_run > 0) begin
            sink_run--;
        end else begin
            sink_gap = gap_len();
            if (sink_gap == 0) begin
                m_tready <= 1'b1;
                sink_run = $urandom_range(0, 6);
            end else begin
                m_tready <= 1'b0;
                sink_run = sink_gap - 1;
            end
        end
    end

    task automatic send_block(input sdes_op_e op, input logic [7:0] blk);
        int gap;
        gap = src_no_idle ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait on the clock before checking so the last accepted block is already recorded
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_blocks.size() != 0);
    endtask

    task automatic write_key(input logic [9:0] key);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        do @(posedge aclk); while (!cfg_ready);
        key_shadow = key;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_both_ops(input logic [7:0] blk);
        send_block(OP_ENCRYPT, blk);
        send_block(OP_DECRYPT, blk);
    endtask

    task automatic test_reset_key();
        send_both_ops(8'h00);
        send_both_ops(8'hFF);
    endtask

    task automatic test_directed_keys();
        write_key(10'h3FF);
        send_both_ops(8'h00);
        send_both_ops(8'hFF);
        send_both_ops(8'h55);
        send_both_ops(8'hAA);
        write_key(10'b1010000010);
        send_block(OP_ENCRYPT, 8'b10010111);
        send_block(OP_DECRYPT, 8'b00111000);
        write_key(10'h000);
        send_block(OP_ENCRYPT, 8'h5A);
        send_block(OP_DECRYPT, 8'hA5);
    endtask

    task automatic test_backpressure();
        write_key(10'($urandom_range(0, KEY_MAX)));
        src_no_idle = 1'b1;
        hold_req_count++;
        repeat (24) send_block(sdes_op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        src_no_idle = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_phases();
        logic [9:0] key;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: key = 10'h000;
                1: key = 10'h3FF;
                default: key = 10'($urandom_range(0, KEY_MAX));
            endcase
            write_key(key);
            src_no_idle  = (ph == 2) || (ph == 5);
            sink_no_idle = (ph == 2) || (ph == 6);
            repeat (PHASE_BLOCKS) begin
                send_block(sdes_op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            src_no_idle  = 1'b0;
            sink_no_idle = 1'b0;
        end
    endtask

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        key_shadow   = '0;
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_key();
        test_directed_keys();
        test_backpressure();
        test_random_phases();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_blocks.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_blocks.size()));
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* simplified_des_cipher_top.f */
+incdir+sv
sv/sdes_pkg.sv
sv/sdes_key_sched.sv
sv/sdes_round.sv
sv/simplified_des_cipher_top.sv
sv/sdes_checker.sv
bench/simplified_des_cipher_top_tb.sv
